### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sst_pkg.sv
package sst_pkg;

  typedef enum logic [2:0] {
    OP_OPEN  = 3'd0,
    OP_CLOSE = 3'd1,
    OP_DECL  = 3'd2,
    OP_REF   = 3'd3,
    OP_FENT  = 3'd4,
    OP_PROTO = 3'd5,
    OP_FDEF  = 3'd6,
    OP_FEND  = 3'd7
  } op_t;

  localparam logic [2:0] CL_NEW  = 3'd0;
  localparam logic [2:0] CL_FUNC = 3'd1;
  localparam logic [2:0] CL_VAR  = 3'd3;
  localparam logic [2:0] CL_PROT = 3'd4;

  localparam int ERR_DUP      = 0;
  localparam int ERR_VOID     = 1;
  localparam int ERR_UNDECL   = 2;
  localparam int ERR_REFUNC   = 3;
  localparam int ERR_NESTPROT = 4;
  localparam int ERR_TYPE     = 5;
  localparam int ERR_NPARAM   = 6;
  localparam int ERR_FULL     = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MAKE,
    ST_ENT,
    ST_OPEN,
    ST_CLOSE,
    ST_BLK_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] name_id;
    logic        type_code;
    logic [2:0]  class_code;
    logic [7:0]  entry_index;
    logic [15:0] code_address;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         result_index;
    logic               found;
    logic               entry_type;
    logic [2:0]         entry_class;
    logic [4:0]         entry_level;
    logic signed [15:0] entry_location;
    logic [7:0]         error_flags;
    logic               patch_valid;
    logic signed [15:0] patch_address;
    logic [15:0]        patch_value;
  } res_t;

endpackage

### rtl/scoped_symbol_table_top.sv
// Channel   Ports               Transaction
// command   start, busy, cmd    taken when start is high and busy is low
// result    done, res           res valid for the single cycle done is high
//
// One result per command. Scans look at one entry at a time (read,
// then compare), and done rises in the same cycle that busy drops.
// The entry RAM's one read port sets the pace. Synchronous reset, no
// clearing pass: the user must see that entries are only read after
// being written; the block itself does not enforce this. The result
// side cannot stall.
`include "assert_macros.svh"

module scoped_symbol_table_top import sst_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int BLOCK_DEPTH = 32,
  parameter int NAME_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t res
);

  localparam int IW = $clog2(TABLE_DEPTH);  // entry address bits
  localparam int LW = $clog2(BLOCK_DEPTH);  // block level bits

  // one table slot as stored in the entry RAM
  typedef struct packed {
    logic [NAME_BITS-1:0] name;
    logic                 etype;
    logic [2:0]           cls;
    logic [LW-1:0]        lvl;
    logic [15:0]          loc;
    logic [7:0]           pcnt;
  } ent_t;

  // saved context of one block level
  typedef struct packed {
    logic [IW:0] first;
    logic [15:0] alloc;
  } blk_t;

  state_t state, state_next;
  logic   done_next;

  // latched command
  op_t                  op;
  logic [NAME_BITS-1:0] name;
  logic                 tcode;
  logic [2:0]           ccode;
  logic [IW-1:0]        eaddr;
  logic [15:0]          fstart;

  // table context
  logic [IW:0]   top;
  logic [LW-1:0] level;
  logic [15:0]   alloc;
  logic [15:0]   maxf;
  logic [IW:0]   cur_first;   // first slot of the current block
  logic [15:0]   cur_alloc;   // allocator on entry to the current block
  logic [IW:0]   ptr;         // scan pointer

  // entry RAM ports
  logic          ent_we;
  logic [IW-1:0] ent_waddr, ent_raddr;
  ent_t          ent_wdata, ent_rdata;

  // block RAM ports
  logic          blk_we;
  logic [LW-1:0] blk_waddr, blk_raddr;
  blk_t          blk_wdata, blk_rdata;

  logic          scan_up, scan_end, scan_hit, tbl_full, blk_full;
  logic [IW-1:0] scan_addr;
  logic [15:0]   maxf_new;
  logic [7:0]    nparam;
  logic          def_bad;
  ent_t          new_ent, upd_ent;

  sst_ram #(.WIDTH($bits(ent_t)), .DEPTH(TABLE_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  sst_ram #(.WIDTH($bits(blk_t)), .DEPTH(BLOCK_DEPTH)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  // -- shared datapath terms --
  assign scan_up   = (op == OP_DECL);            // duplicate check walks upwards
  assign scan_end  = scan_up ? (ptr >= top) : (ptr <= (IW+1)'(1));
  assign scan_addr = scan_up ? ptr[IW-1:0] : IW'(ptr - (IW+1)'(1));
  assign scan_hit  = (ent_rdata.name == name);
  assign tbl_full  = (int'(top) >= TABLE_DEPTH);
  assign blk_full  = (int'(level) + 1 >= BLOCK_DEPTH);
  assign maxf_new  = (alloc > maxf) ? alloc : maxf;
  assign nparam    = 8'(top - cur_first);
  assign def_bad   = (ent_rdata.cls != CL_NEW) && (ent_rdata.cls != CL_PROT);

  // slot built by a declare, a reference miss or a new function name
  always_comb begin
    new_ent      = '0;
    new_ent.name = name;
    new_ent.lvl  = level;
    unique case (op)
      OP_DECL: begin
        new_ent.etype = 1'b1;   // void is promoted to int
        new_ent.cls   = ccode;
        new_ent.loc   = alloc;
      end
      OP_REF: begin
        new_ent.etype = 1'b1;
        new_ent.cls   = CL_VAR;
      end
      default: begin
        new_ent.etype = 1'b0;
        new_ent.cls   = CL_NEW;
      end
    endcase
  end

  // function slot rewritten by prototype or definition
  always_comb begin
    upd_ent = ent_rdata;
    if (op == OP_PROTO) begin
      upd_ent.cls   = CL_PROT;
      upd_ent.etype = tcode;
      upd_ent.loc   = 16'hFFFF;
      upd_ent.pcnt  = nparam;
    end else if (op == OP_FDEF && !def_bad) begin
      if (ent_rdata.cls == CL_NEW) begin
        upd_ent.etype = tcode;
        upd_ent.pcnt  = nparam;
      end
      upd_ent.cls = CL_FUNC;
      upd_ent.loc = fstart;
    end
  end

  // -- next state --
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (op) inside
          OP_OPEN:                    state_next = ST_OPEN;
          OP_CLOSE:                   state_next = ST_CLOSE;
          OP_DECL, OP_REF, OP_FENT:   state_next = ST_SCAN_RD;
          default:                    state_next = ST_ENT;
        endcase
      end
      ST_SCAN_RD:  state_next = scan_end ? ST_MAKE : ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!scan_hit)           state_next = ST_SCAN_RD;
        else if (op == OP_FENT)  state_next = ST_OPEN;
        else                     state_next = ST_IDLE;
      end
      ST_MAKE:     state_next = (op == OP_FENT) ? ST_OPEN : ST_IDLE;
      ST_ENT:      state_next = (op == OP_FDEF) ? ST_IDLE : ST_CLOSE;
      ST_OPEN:     state_next = ST_IDLE;
      ST_CLOSE:    state_next = (level != '0) ? ST_BLK_WAIT : ST_IDLE;
      ST_BLK_WAIT: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // -- outputs and RAM controls --
  always_comb begin
    busy      = (state != ST_IDLE);
    done_next = (state != ST_IDLE) && (state_next == ST_IDLE);
    ent_we    = 1'b0;
    ent_waddr = top[IW-1:0];
    ent_wdata = new_ent;
    ent_raddr = scan_addr;
    blk_we    = 1'b0;
    blk_waddr = level;
    blk_wdata = '{first: cur_first, alloc: cur_alloc};
    blk_raddr = LW'(level - LW'(1));
    unique case (state)
      ST_DISPATCH: ent_raddr = eaddr;
      ST_MAKE:     ent_we    = !tbl_full;
      ST_ENT: begin
        ent_waddr = eaddr;
        ent_wdata = upd_ent;
        ent_we    = (op == OP_PROTO) || (op == OP_FDEF && !def_bad);
      end
      ST_OPEN:     blk_we = !blk_full;
      default: ;
    endcase
  end

  // -- registers --
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      top       <= (IW+1)'(1);
      level     <= '0;
      alloc     <= '0;
      maxf      <= '0;
      cur_first <= (IW+1)'(1);
      cur_alloc <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op     <= op_t'(cmd.opcode);
            name   <= NAME_BITS'(cmd.name_id);
            tcode  <= cmd.type_code;
            ccode  <= cmd.class_code;
            // indices past the table fall back to the scratch slot
            eaddr  <= (int'(cmd.entry_index) >= TABLE_DEPTH) ? '0 : IW'(cmd.entry_index);
            fstart <= cmd.code_address + 16'd3;
            res    <= '0;
          end
        end
        ST_DISPATCH: ptr <= (op == OP_DECL) ? cur_first : top;
        ST_SCAN_RD: ;
        ST_SCAN_CHK: begin
          if (scan_hit) begin
            res.result_index   <= 8'(scan_addr);
            res.found          <= 1'b1;
            res.entry_type     <= ent_rdata.etype;
            res.entry_class    <= ent_rdata.cls;
            res.entry_level    <= 5'(ent_rdata.lvl);
            res.entry_location <= ent_rdata.loc;
            if (op == OP_DECL) res.error_flags[ERR_DUP] <= 1'b1;
            if (op == OP_FENT) begin
              res.error_flags[ERR_REFUNC] <= (ent_rdata.cls != CL_PROT);
              alloc <= 16'd1;
              maxf  <= 16'd1;
            end
          end else if (scan_up) begin
            ptr <= ptr + (IW+1)'(1);
          end else begin
            ptr <= ptr - (IW+1)'(1);
          end
        end
        ST_MAKE: begin
          if (op == OP_DECL && !tcode) res.error_flags[ERR_VOID] <= 1'b1;
          if (op == OP_REF) res.error_flags[ERR_UNDECL] <= 1'b1;
          if (tbl_full) begin
            res.error_flags[ERR_FULL] <= 1'b1;
          end else begin
            top                <= top + (IW+1)'(1);
            res.result_index   <= 8'(top);
            res.entry_type     <= new_ent.etype;
            res.entry_class    <= new_ent.cls;
            res.entry_level    <= 5'(new_ent.lvl);
            res.entry_location <= new_ent.loc;
            if (op == OP_DECL) alloc <= alloc + 16'd1;
          end
          if (op == OP_FENT) begin
            alloc <= 16'd1;
            maxf  <= 16'd1;
          end
        end
        ST_ENT: begin
          res.result_index   <= 8'(eaddr);
          res.entry_type     <= upd_ent.etype;
          res.entry_class    <= upd_ent.cls;
          res.entry_level    <= 5'(upd_ent.lvl);
          res.entry_location <= upd_ent.loc;
          unique case (op)
            OP_PROTO: res.error_flags[ERR_NESTPROT] <= (level > LW'(1));
            OP_FDEF: begin
              if (def_bad) begin
                res.error_flags[ERR_REFUNC] <= 1'b1;
              end else if (ent_rdata.cls == CL_PROT) begin
                res.error_flags[ERR_TYPE]   <= (ent_rdata.etype != tcode);
                res.error_flags[ERR_NPARAM] <= (ent_rdata.pcnt != nparam);
                res.patch_valid   <= 1'b1;
                res.patch_address <= ent_rdata.loc;
                res.patch_value   <= fstart;
              end
            end
            default: begin
              // end of a definition: patch the frame size in
              if (ent_rdata.cls == CL_FUNC) begin
                res.patch_valid   <= 1'b1;
                res.patch_address <= ent_rdata.loc;
                res.patch_value   <= maxf_new;
              end
            end
          endcase
        end
        ST_OPEN: begin
          if (blk_full) begin
            res.error_flags[ERR_FULL] <= 1'b1;
          end else begin
            level     <= level + LW'(1);
            cur_first <= top;
            cur_alloc <= alloc;
          end
        end
        ST_CLOSE: begin
          maxf  <= maxf_new;
          top   <= cur_first;
          alloc <= cur_alloc;
          if (level != '0) level <= level - LW'(1);
        end
        ST_BLK_WAIT: begin
          cur_first <= blk_rdata.first;
          cur_alloc <= blk_rdata.alloc;
        end
        default: ;
      endcase
    end
  end

  // -- checks --
  `ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "command taken but not busy")
  `ASSERT_NOW(a_top_nonzero, clk, rst, 1'b1, top != '0, "table top reached scratch slot")

endmodule

### rtl/sst_ram.sv
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
